// File: design/jpdm_pkg.sv
// Shared constants, types and arctangent step constants for the joystick polar drive mixer.
package jpdm_pkg;

  localparam int ANGLE_FRAC_BITS = 16;
  localparam int CORDIC_STAGES   = 16;
  localparam int STAGE_W         = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;

  localparam int IN_W       = 8;
  localparam int OUT_W      = 9;
  localparam int WORK_SHIFT = 30;
  localparam int UV_W       = 41;
  localparam int ANG_W      = 32;
  localparam int Z_W        = ANG_W + 3;

  localparam int SQ_W        = 16;
  localparam int ISQRT_STEPS = 8;
  localparam int ISQRT_TOP   = 14;
  localparam int MAG_W       = 9;

  localparam int MOD_W  = ANGLE_FRAC_BITS + 2;
  localparam int PROD_W = MAG_W + 1 + MOD_W;
  localparam logic signed [MOD_W-1:0] MOD_ONE = MOD_W'(2 ** ANGLE_FRAC_BITS);

  localparam logic [63:0] HALF_PI_Q62 = 64'h6487_ED51_10B4_611A;

  typedef enum logic [1:0] {
    QUAD_0,
    QUAD_1,
    QUAD_2,
    QUAD_3
  } quad_t;

  typedef struct packed {
    logic signed [UV_W-1:0] u;
    logic signed [UV_W-1:0] v;
    logic signed [Z_W-1:0]  z;
    quad_t                  quad;
    logic                   origin;
    logic [SQ_W-1:0]        sq_rem;
    logic [SQ_W-1:0]        root;
  } cell_data_t;

  // Floor of two to the power e over d, by long division.
  function automatic logic [63:0] pow2_over(int e, logic [63:0] d);
    logic [63:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int n = 63; n >= 0; n--) begin
      rem = {rem[62:0], (n == e)};
      quo = {quo[62:0], 1'b0};
      if (rem >= d) begin
        rem = rem - d;
        quo[0] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Arctangent of two to the power minus i, in units of a quarter turn scaled by 2^32.
  function automatic logic [ANG_W-1:0] atan_entry(int i);
    logic [63:0] r;
    logic [63:0] rem;
    logic [ANG_W-1:0] quo;
    int e;
    r   = '0;
    quo = '0;
    if (i == 0) begin
      return ANG_W'(64'h8000_0000);
    end
    for (int k = 0; k < 32; k++) begin
      e = 62 - i * (2 * k + 1);
      if (e >= 0) begin
        if (k % 2 == 1) begin
          r = r - pow2_over(e, 64'(2 * k + 1));
        end else begin
          r = r + pow2_over(e, 64'(2 * k + 1));
        end
      end
    end
    rem = r;
    for (int n = 0; n < ANG_W; n++) begin
      rem = {rem[62:0], 1'b0};
      quo = {quo[ANG_W-2:0], 1'b0};
      if (rem >= HALF_PI_Q62) begin
        rem = rem - HALF_PI_Q62;
        quo[0] = 1'b1;
      end
    end
    return quo;
  endfunction

endpackage

// File: design/jpdm_prep.sv
// Input stage: quadrant fold, CORDIC seed vector and sum of squares.
module jpdm_prep import jpdm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   up_valid,
  output logic                   up_ready,
  input  logic signed [IN_W-1:0] joy_x,
  input  logic signed [IN_W-1:0] joy_y,
  output logic                   dn_valid,
  input  logic                   dn_ready,
  output cell_data_t             dn_data
);

  logic                   valid_r;
  cell_data_t             data_r;
  cell_data_t             data_nxt;
  logic signed [IN_W:0]   x_e;
  logic signed [IN_W:0]   y_e;
  logic signed [IN_W:0]   u_s;
  logic signed [IN_W:0]   v_s;
  logic signed [2*IN_W-1:0] xx;
  logic signed [2*IN_W-1:0] yy;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_comb begin
    x_e = {joy_x[IN_W-1], joy_x};
    y_e = {joy_y[IN_W-1], joy_y};
    xx  = joy_x * joy_x;
    yy  = joy_y * joy_y;
    data_nxt.origin = (joy_x == '0) && (joy_y == '0);
    if (data_nxt.origin) begin
      data_nxt.quad = QUAD_0;
      u_s = '0;
      v_s = '0;
    end else if (joy_x > 0 && joy_y >= 0) begin
      data_nxt.quad = QUAD_0;
      u_s = x_e;
      v_s = y_e;
    end else if (joy_x <= 0 && joy_y > 0) begin
      data_nxt.quad = QUAD_1;
      u_s = y_e;
      v_s = -x_e;
    end else if (joy_x < 0 && joy_y <= 0) begin
      data_nxt.quad = QUAD_2;
      u_s = -x_e;
      v_s = -y_e;
    end else begin
      data_nxt.quad = QUAD_3;
      u_s = -y_e;
      v_s = x_e;
    end
    data_nxt.u = {{(UV_W-IN_W-1-WORK_SHIFT){u_s[IN_W]}}, u_s, {WORK_SHIFT{1'b0}}};
    data_nxt.v = {{(UV_W-IN_W-1-WORK_SHIFT){v_s[IN_W]}}, v_s, {WORK_SHIFT{1'b0}}};
    data_nxt.z = '0;
    data_nxt.sq_rem = SQ_W'(xx) + SQ_W'(yy);
    data_nxt.root   = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

// File: design/jpdm_cell.sv
// One link of the chain: a CORDIC vectoring step and, in the first links, one square-root step.
module jpdm_cell import jpdm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [STAGE_W-1:0] idx,
  input  logic [ANG_W-1:0]   atan_step,
  input  logic               up_valid,
  output logic               up_ready,
  input  cell_data_t         up_data,
  output logic               dn_valid,
  input  logic               dn_ready,
  output cell_data_t         dn_data
);

  logic                   valid_r;
  cell_data_t             data_r;
  cell_data_t             data_nxt;
  logic signed [UV_W-1:0] du;
  logic signed [UV_W-1:0] dv;
  logic signed [Z_W-1:0]  dz;
  logic                   sq_act;
  logic [SQ_W-1:0]        sq_bit;
  logic [SQ_W:0]          trial;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_comb begin
    data_nxt = up_data;
    du = up_data.v >>> idx;
    dv = up_data.u >>> idx;
    dz = {{(Z_W-ANG_W){1'b0}}, atan_step};
    if (!up_data.v[UV_W-1]) begin
      data_nxt.u = up_data.u + du;
      data_nxt.v = up_data.v - dv;
      data_nxt.z = up_data.z + dz;
    end else begin
      data_nxt.u = up_data.u - du;
      data_nxt.v = up_data.v + dv;
      data_nxt.z = up_data.z - dz;
    end
    sq_act = int'(idx) < ISQRT_STEPS;
    sq_bit = sq_act ? (SQ_W'(1) << (ISQRT_TOP - 2 * int'(idx))) : '0;
    trial  = {1'b0, up_data.root} + {1'b0, sq_bit};
    if (sq_act) begin
      if ({1'b0, up_data.sq_rem} >= trial) begin
        data_nxt.sq_rem = up_data.sq_rem - trial[SQ_W-1:0];
        data_nxt.root   = (up_data.root >> 1) + sq_bit;
      end else begin
        data_nxt.root   = up_data.root >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

// File: design/jpdm_mix.sv
// Output stage: angle fraction, motor modifiers, scaling and the result register.
module jpdm_mix import jpdm_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    up_valid,
  output logic                    up_ready,
  input  cell_data_t              up_data,
  output logic                    dn_valid,
  input  logic                    dn_ready,
  output logic signed [OUT_W-1:0] left_speed,
  output logic signed [OUT_W-1:0] right_speed
);

  logic                          valid_r;
  logic signed [OUT_W-1:0]       left_r;
  logic signed [OUT_W-1:0]       right_r;
  logic signed [OUT_W-1:0]       left_nxt;
  logic signed [OUT_W-1:0]       right_nxt;
  logic [ANG_W-1:0]              z_clamp;
  logic [ANGLE_FRAC_BITS-1:0]    frac;
  logic signed [MOD_W-1:0]       frac2;
  logic signed [MOD_W-1:0]       left_mod;
  logic signed [MOD_W-1:0]       right_mod;
  logic signed [MAG_W:0]         mag;
  logic signed [PROD_W-1:0]      left_prod;
  logic signed [PROD_W-1:0]      right_prod;

  function automatic logic signed [OUT_W-1:0] scale_trunc(logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] mag_p;
    logic signed [PROD_W-1:0] res;
    if (p[PROD_W-1]) begin
      mag_p = -p;
      res   = -(mag_p >>> ANGLE_FRAC_BITS);
    end else begin
      res   = p >>> ANGLE_FRAC_BITS;
    end
    return res[OUT_W-1:0];
  endfunction

  assign up_ready    = !valid_r || dn_ready;
  assign dn_valid    = valid_r;
  assign left_speed  = left_r;
  assign right_speed = right_r;

  always_comb begin
    if (up_data.z[Z_W-1]) begin
      z_clamp = '0;
    end else if (up_data.z[Z_W-2:ANG_W] != '0) begin
      z_clamp = '1;
    end else begin
      z_clamp = up_data.z[ANG_W-1:0];
    end
    frac  = up_data.origin ? '0 : z_clamp[ANG_W-1 -: ANGLE_FRAC_BITS];
    frac2 = {1'b0, frac, 1'b0};
    case (up_data.quad)
      QUAD_0: begin
        left_mod  = MOD_ONE;
        right_mod = frac2 - MOD_ONE;
      end
      QUAD_1: begin
        left_mod  = MOD_ONE - frac2;
        right_mod = MOD_ONE;
      end
      QUAD_2: begin
        left_mod  = -MOD_ONE;
        right_mod = MOD_ONE - frac2;
      end
      default: begin
        left_mod  = frac2 - MOD_ONE;
        right_mod = -MOD_ONE;
      end
    endcase
    mag        = {1'b0, up_data.root[MAG_W-1:0]};
    left_prod  = mag * left_mod;
    right_prod = mag * right_mod;
    left_nxt   = scale_trunc(left_prod);
    right_nxt  = scale_trunc(right_prod);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      left_r  <= left_nxt;
      right_r <= right_nxt;
    end
  end

endmodule

// File: design/joystick_polar_drive_mixer_core.sv
// Top level of the joystick polar drive mixer: input stage, CORDIC chain and output stage.
//
// The input channel (in_valid, in_ready) takes one joystick sample, in_joy_x and in_joy_y,
// as signed 8-bit values. The output channel (out_valid, out_ready) gives one pair of
// signed 9-bit motor speeds, out_left_speed and out_right_speed, for every sample taken.
// Each speed is the truncated product of the vector magnitude and a modifier that is
// piecewise linear in the vector angle; the origin gives zero on both motors.
// The datapath is a chain of CORDIC_STAGES + 2 registered links: the input stage, one
// link per CORDIC vectoring step (the first eight also take one square-root step each)
// and the output register. One sample is taken every cycle while results are drained.
// Every link holds its own valid flag and takes a new transaction whenever it is empty or
// passing its contents on, so a stalled receiver only halts the links that are full;
// in_ready falls once every link holds a transaction.
// A synchronous reset empties the chain; payload registers are not reset.
module joystick_polar_drive_mixer_core import jpdm_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [IN_W-1:0]  in_joy_x,
  input  logic signed [IN_W-1:0]  in_joy_y,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [OUT_W-1:0] out_left_speed,
  output logic signed [OUT_W-1:0] out_right_speed
);

  cell_data_t chain_data  [CORDIC_STAGES+1];
  logic       chain_valid [CORDIC_STAGES+1];
  logic       chain_ready [CORDIC_STAGES+1];

  jpdm_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .joy_x    (in_joy_x),
    .joy_y    (in_joy_y),
    .dn_valid (chain_valid[0]),
    .dn_ready (chain_ready[0]),
    .dn_data  (chain_data[0])
  );

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    localparam logic [ANG_W-1:0] AtanStep = atan_entry(g);

    jpdm_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .idx       (STAGE_W'(g)),
      .atan_step (AtanStep),
      .up_valid  (chain_valid[g]),
      .up_ready  (chain_ready[g]),
      .up_data   (chain_data[g]),
      .dn_valid  (chain_valid[g+1]),
      .dn_ready  (chain_ready[g+1]),
      .dn_data   (chain_data[g+1])
    );
  end

  jpdm_mix u_mix (
    .clk         (clk),
    .rst_n       (rst_n),
    .up_valid    (chain_valid[CORDIC_STAGES]),
    .up_ready    (chain_ready[CORDIC_STAGES]),
    .up_data     (chain_data[CORDIC_STAGES]),
    .dn_valid    (out_valid),
    .dn_ready    (out_ready),
    .left_speed  (out_left_speed),
    .right_speed (out_right_speed)
  );

endmodule

// File: design/jpdm_checker.sv
// Port-level checks for the joystick polar drive mixer, bound to the top level.
module jpdm_checker import jpdm_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic signed [IN_W-1:0]  in_joy_x,
  input logic signed [IN_W-1:0]  in_joy_y,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [OUT_W-1:0] out_left_speed,
  input logic signed [OUT_W-1:0] out_right_speed
);

  // A held result keeps both speeds until the transaction completes.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_left_speed)
                               && $stable(out_right_speed))
    else $error("result changed while stalled");

  // Reset empties every link, so nothing is offered and a sample can be taken.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("chain not empty after reset");

  // The magnitude never exceeds 181, so neither speed can go beyond it.
  a_left_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_left_speed <= 181 && out_left_speed >= -181)
    else $error("left speed out of range");

  a_right_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_right_speed <= 181 && out_right_speed >= -181)
    else $error("right speed out of range");

endmodule

bind joystick_polar_drive_mixer_core jpdm_checker u_jpdm_checker (.*);
